// ===== hdl/pagt_pkg.sv =====
// Shared types and register-map constants for the private and global timer.
package pagt_pkg;

  // Request kinds
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register blocks
  localparam logic BLK_PRIVATE = 1'b0;
  localparam logic BLK_GLOBAL  = 1'b1;

  // Private timer word offsets
  localparam logic [1:0] PRV_LOAD    = 2'd0;
  localparam logic [1:0] PRV_COUNTER = 2'd1;
  localparam logic [1:0] PRV_CONTROL = 2'd2;
  localparam logic [1:0] PRV_STATUS  = 2'd3;

  // Global timer word offsets
  localparam logic [1:0] GLB_COUNT_LO = 2'd0;
  localparam logic [1:0] GLB_COUNT_HI = 2'd1;
  localparam logic [1:0] GLB_CONTROL  = 2'd2;

  // Private control bits
  localparam int CTRL_ENABLE_BIT = 0;
  localparam int CTRL_AUTO_BIT   = 1;
  localparam int CTRL_IRQ_BIT    = 2;

  localparam int DATA_W   = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [1:0]        command;
    logic              block_select;
    logic [1:0]        reg_index;
    logic [DATA_W-1:0] write_data;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              timer_irq;
  } result_t;

  // Current interrupt state seen by the top level
  typedef struct packed {
    logic event_flag;
    logic irq_on;
  } irq_status_t;

endpackage

// ===== hdl/pagt_core.sv =====
// Timer state registers and the single-pass update for one request.
module pagt_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  pagt_pkg::request_t    req,
  output pagt_pkg::result_t     res,
  output pagt_pkg::irq_status_t status
);

  logic [31:0] reload_value, reload_value_next;
  logic [31:0] down_count, down_count_next;
  logic [2:0]  control_bits, control_bits_next;
  logic [7:0]  prescale_limit, prescale_limit_next;
  logic [7:0]  prescale_count, prescale_count_next;
  logic        event_flag, event_flag_next;
  logic [63:0] global_count, global_count_next;
  logic [3:0]  global_control, global_control_next;
  logic [31:0] rd;

  always_comb begin
    reload_value_next   = reload_value;
    down_count_next     = down_count;
    control_bits_next   = control_bits;
    prescale_limit_next = prescale_limit;
    prescale_count_next = prescale_count;
    event_flag_next     = event_flag;
    global_count_next   = global_count;
    global_control_next = global_control;
    rd                  = '0;

    case (req.command)
      pagt_pkg::CMD_TICK: begin
        if (global_control[0]) begin
          global_count_next = global_count + 64'd1;
        end
        if (control_bits[pagt_pkg::CTRL_ENABLE_BIT]) begin
          if (prescale_count >= prescale_limit) begin
            prescale_count_next = '0;
            if (down_count != '0) begin
              down_count_next = down_count - 32'd1;
              if (down_count == 32'd1) begin
                event_flag_next = 1'b1;
              end
            end else if (control_bits[pagt_pkg::CTRL_AUTO_BIT]) begin
              down_count_next = reload_value;
              if (reload_value == '0) begin
                event_flag_next = 1'b1;
              end
            end
          end else begin
            prescale_count_next = prescale_count + 8'd1;
          end
        end
      end
      pagt_pkg::CMD_READ: begin
        if (req.block_select == pagt_pkg::BLK_PRIVATE) begin
          case (req.reg_index)
            pagt_pkg::PRV_LOAD:    rd = reload_value;
            pagt_pkg::PRV_COUNTER: rd = down_count;
            pagt_pkg::PRV_CONTROL: rd = {16'd0, prescale_limit, 5'd0, control_bits};
            default:               rd = {31'd0, event_flag};
          endcase
        end else begin
          case (req.reg_index)
            pagt_pkg::GLB_COUNT_LO: rd = global_count[31:0];
            pagt_pkg::GLB_COUNT_HI: rd = global_count[63:32];
            pagt_pkg::GLB_CONTROL:  rd = {28'd0, global_control};
            default:                rd = '0;
          endcase
        end
      end
      pagt_pkg::CMD_WRITE: begin
        if (req.block_select == pagt_pkg::BLK_PRIVATE) begin
          case (req.reg_index)
            pagt_pkg::PRV_LOAD: begin
              reload_value_next = req.write_data;
              down_count_next   = req.write_data;
            end
            pagt_pkg::PRV_COUNTER: down_count_next = req.write_data;
            pagt_pkg::PRV_CONTROL: begin
              control_bits_next   = req.write_data[2:0];
              prescale_limit_next = req.write_data[15:8];
            end
            default: begin
              if (req.write_data[0]) begin
                event_flag_next = 1'b0;
              end
            end
          endcase
        end else if (req.reg_index == pagt_pkg::GLB_CONTROL) begin
          global_control_next = req.write_data[3:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value   <= '0;
      down_count     <= '0;
      control_bits   <= '0;
      prescale_limit <= '0;
      prescale_count <= '0;
      event_flag     <= 1'b0;
      global_count   <= '0;
      global_control <= '0;
    end else if (go) begin
      reload_value   <= reload_value_next;
      down_count     <= down_count_next;
      control_bits   <= control_bits_next;
      prescale_limit <= prescale_limit_next;
      prescale_count <= prescale_count_next;
      event_flag     <= event_flag_next;
      global_count   <= global_count_next;
      global_control <= global_control_next;
    end
  end

  assign res.read_data = rd;
  assign res.timer_irq = event_flag_next & control_bits_next[pagt_pkg::CTRL_IRQ_BIT];

  assign status.event_flag = event_flag;
  assign status.irq_on     = control_bits[pagt_pkg::CTRL_IRQ_BIT];

endmodule

// ===== hdl/private_and_global_timer.sv =====
// Top level: request register, timer core and result register.
// Private 32-bit down-counting timer and 64-bit global up-counter.
// Requests enter on the s_ group: s_tuser carries the request kind (tick,
// bus read, bus write) and the register block; s_tdata carries the word
// offset and the write data. Each request gives exactly one result on the
// m_ group: read data (zero unless a read) and the interrupt line as it
// stands after the request.
// An accepted request is held in the request register; one pass through
// the core loads the result register, which offers the result until the
// receiver takes it.
// Throughput: one request per cycle unless the receiver stalls; the core
// updates every timer register in a single pass, so a tick counts in every cycle.
// When the receiver stalls, the result register holds, then the request
// register fills, then s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears every timer register and both valid
// flags; the block accepts requests in the first cycle after reset.
module private_and_global_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] reg_index, [33:2] write_data, rest zero
  input  logic [2:0]  s_tuser,   // [1:0] command, [2] block_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] read_data, [32] timer_irq, rest zero
);

  pagt_pkg::request_t    req;
  logic                  req_valid;
  pagt_pkg::result_t     res_comb;
  pagt_pkg::result_t     res;
  logic                  res_valid;
  pagt_pkg::irq_status_t status;
  logic                  advance;

  // Move the held request into the core when the result slot frees up
  assign advance  = req_valid & (~res_valid | m_tready);
  assign s_tready = ~req_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  // Capture request payload; no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid & s_tready) begin
      req.command      <= s_tuser[1:0];
      req.block_select <= s_tuser[2];
      req.reg_index    <= s_tdata[1:0];
      req.write_data   <= s_tdata[33:2];
    end
  end

  pagt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .req    (req),
    .res    (res_comb),
    .status (status)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {7'd0, res.timer_irq, res.read_data};

`ifndef SYNTH
  // A request moved into the core must show up as a result next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("request advanced but no result followed");

  // Timer state only changes with a new result, so a held result's
  // interrupt bit must match the live flag and enable
  a_irq_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32] == (status.event_flag & status.irq_on)))
    else $error("result interrupt bit disagrees with timer state");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("pipeline not empty after reset");
`endif

endmodule
